@@ src/fnv64_pkg.sv @@
package fnv64_pkg;

  localparam int unsigned HashWidth = 64;
  localparam int unsigned ByteWidth = 8;

  localparam logic [HashWidth-1:0] FnvOffsetBasis = 64'hcbf29ce484222325;

  // Register indexes on the configuration port.
  localparam logic CfgMixMode   = 1'b0;
  localparam logic CfgFoldWidth = 1'b1;

  // Result width codes.
  localparam logic [1:0] FoldTo16 = 2'd0;
  localparam logic [1:0] FoldTo32 = 2'd1;
  localparam logic [1:0] FoldTo64 = 2'd2;

  function automatic logic [HashWidth-1:0] fold_hash(input logic [HashWidth-1:0] h,
                                                     input logic [1:0] sel);
    logic [HashWidth-1:0] r;
    r = h;
    case (sel)
      FoldTo16: r = {48'd0, h[15:0] ^ h[31:16] ^ h[47:32] ^ h[63:48]};
      FoldTo32: r = {32'd0, h[31:0] ^ h[63:32]};
      FoldTo64: r = h;
      default:  r = h;
    endcase
    return r;
  endfunction

endpackage

@@ src/fnv1a_64_byte_hash_unit.sv @@
// Channel  | Direction | Payload
// s_axis   | in        | tdata: data_byte; tuser: byte_present, no_data; tlast: last
// m_axis   | out       | tdata: hash_value
// cfg      | in        | cfg_index_i: register index; cfg_data_i: value
//
// One byte is taken every cycle while the input is not stalled; a request waits in the
// input register, and its result is then written into the output register.
// The hash register feeds back through one mix and shift-add multiply per cycle in which a request advances.
// Reset sets the running hash to the offset basis, mix_mode to 1 and fold_width to 2.
// A stalled result holds the output register; input stalls only when a result
// request waits behind a full, unread output register.
module fnv1a_64_byte_hash_unit
  import fnv64_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [ByteWidth-1:0] s_axis_tdata,  // [7:0] data_byte
  input  logic [1:0]           s_axis_tuser,  // [0] byte_present, [1] no_data
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [HashWidth-1:0] m_axis_tdata,  // [63:0] hash_value
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_index_i,
  input  logic [1:0]           cfg_data_i
);

  logic                 in_valid_q;
  logic [ByteWidth-1:0] in_byte_q;
  logic                 in_present_q;
  logic                 in_last_q;
  logic                 in_nodata_q;

  logic [HashWidth-1:0] hash_q, hash_d;
  logic [HashWidth-1:0] step_hash;
  logic [HashWidth-1:0] cur_hash;
  logic                 mix_mode_q;
  logic [1:0]           fold_width_q;

  logic                 out_valid_q;
  logic [HashWidth-1:0] out_data_q;

  logic                 gives_result;
  logic                 advance;
  logic                 in_accept;

  fnv64_step u_step (
    .hash_i  (hash_q),
    .byte_i  (in_byte_q),
    .tweak_i (mix_mode_q),
    .hash_o  (step_hash)
  );

  assign gives_result  = in_last_q | in_nodata_q;
  assign advance       = in_valid_q & (~gives_result | ~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;
  assign in_accept     = s_axis_tvalid & s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign cur_hash = in_present_q ? step_hash : hash_q;

  always_comb begin
    hash_d = hash_q;
    if (advance) begin
      hash_d = gives_result ? FnvOffsetBasis : cur_hash;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      hash_q       <= FnvOffsetBasis;
      mix_mode_q   <= 1'b1;
      fold_width_q <= FoldTo64;
    end else begin
      hash_q <= hash_d;
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance && gives_result) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgMixMode:   mix_mode_q   <= cfg_data_i[0];
          CfgFoldWidth: fold_width_q <= cfg_data_i;
          default:      mix_mode_q   <= mix_mode_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q    <= s_axis_tdata;
      in_present_q <= s_axis_tuser[0];
      in_nodata_q  <= s_axis_tuser[1];
      in_last_q    <= s_axis_tlast;
    end
    if (advance && gives_result) begin
      out_data_q <= in_nodata_q ? '0 : fold_hash(cur_hash, fold_width_q);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
  a_null_gives_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_nodata_q |=> m_axis_tvalid && m_axis_tdata == '0)
    else $error("null message did not give a zero result");

  a_hash_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && gives_result |=> hash_q == FnvOffsetBasis)
    else $error("running hash not restarted after a result");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q && gives_result && out_valid_q && !m_axis_tready)
    else $error("input stalled without a blocked result");

  a_hash_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> hash_q == $past(hash_q))
    else $error("running hash changed without a request");
`endif

endmodule

@@ src/fnv64_step.sv @@
module fnv64_step
  import fnv64_pkg::*;
(
  input  logic [HashWidth-1:0] hash_i,
  input  logic [ByteWidth-1:0] byte_i,
  input  logic                 tweak_i,
  output logic [HashWidth-1:0] hash_o
);

  logic [HashWidth-1:0] add_term;
  logic [HashWidth-1:0] xor_term;
  logic [HashWidth-1:0] mixed;

  // The byte copies do not overlap, so they are placed side by side.
  assign add_term = {3'd0, byte_i, 14'd0, byte_i, 12'd0, byte_i, 11'd0};
  assign xor_term = {13'd0, byte_i, 12'd0, byte_i, 15'd0, byte_i};

  always_comb begin
    if (tweak_i) begin
      mixed = (hash_i + add_term) ^ xor_term;
    end else begin
      mixed = hash_i ^ {{(HashWidth-ByteWidth){1'b0}}, byte_i};
    end
  end

  // The FNV prime is 2^40 + 0x1b3, so the product is a sum of shifted copies.
  assign hash_o = (mixed << 40) + (mixed << 8) + (mixed << 7) + (mixed << 5)
                + (mixed << 4) + (mixed << 1) + mixed;

endmodule

@@ tb/fnv1a_64_byte_hash_unit_tb.sv @@
module fnv1a_64_byte_hash_unit_tb;
  import fnv64_pkg::*;

  localparam logic [HashWidth-1:0] FnvPrime = 64'h0000_0100_0000_01b3;
  localparam logic [1:0] FoldUnused = 2'd3;
  localparam int SettleCycles = 6;
  localparam int CycleLimit = 400000;
  localparam int PhaseItems = 250;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [ByteWidth-1:0] s_axis_tdata = '0;
  logic [1:0]           s_axis_tuser = '0;
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b1;
  logic [HashWidth-1:0] m_axis_tdata;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic                 cfg_index_i = 1'b0;
  logic [1:0]           cfg_data_i = '0;

  logic [HashWidth-1:0] hash_state = FnvOffsetBasis;
  logic                 mix_tweaked = 1'b1;
  logic [1:0]           fold_sel = FoldTo64;
  logic [HashWidth-1:0] pending_hashes[$];
  logic [HashWidth-1:0] oldest_hash;

  int  error_count = 0;
  int  cycle_count = 0;
  int  burst_left = 0;
  int  rx_hold = 0;
  bit  tx_gaps_on = 1'b0;
  bit  rx_stall_on = 1'b0;

  fnv1a_64_byte_hash_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [HashWidth-1:0] mixed_hash(input logic [HashWidth-1:0] h,
                                                      input logic [ByteWidth-1:0] b,
                                                      input logic tweaked);
    logic [HashWidth-1:0] w;
    logic [HashWidth-1:0] m;
    w = {56'd0, b};
    m = h;
    if (tweaked) begin
      m = m + ((w << 11) | (w << 31) | (w << 53));
      m = m ^ (w | (w << 23) | (w << 43));
    end else begin
      m = m ^ w;
    end
    return m * FnvPrime;
  endfunction

  function automatic logic [HashWidth-1:0] folded_hash(input logic [HashWidth-1:0] h,
                                                       input logic [1:0] sel);
    logic [HashWidth-1:0] f;
    f = h;
    if (sel == FoldTo16) begin
      f = (h ^ (h >> 16) ^ (h >> 32) ^ (h >> 48)) & 64'hffff;
    end else if (sel == FoldTo32) begin
      f = (h ^ (h >> 32)) & 64'hffff_ffff;
    end
    return f;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  task automatic send_request(input logic [ByteWidth-1:0] b, input logic present,
                              input logic last, input logic nodata);
    if (tx_gaps_on && burst_left <= 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= {nodata, present};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    if (nodata) begin
      pending_hashes.push_back('0);
      hash_state = FnvOffsetBasis;
    end else begin
      if (present) hash_state = mixed_hash(hash_state, b, mix_tweaked);
      if (last) begin
        pending_hashes.push_back(folded_hash(hash_state, fold_sel));
        hash_state = FnvOffsetBasis;
      end
    end
  endtask

  task automatic wait_for_results_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_register(input logic idx, input logic [1:0] value);
    wait_for_results_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CfgMixMode) begin
      mix_tweaked = value[0];
    end else begin
      fold_sel = value;
    end
  endtask

  task automatic send_message_stream(input int item_budget);
    int sent;
    int len;
    bit split_end;
    logic is_last;
    sent = 0;
    while (sent < item_budget) begin
      if ($urandom_range(0, 19) == 0) begin
        send_request(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'b1);
        sent++;
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
        split_end = (len == 0) || ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++) begin
          is_last = (i == len - 1) && !split_end;
          send_request(8'($urandom_range(0, 255)), $urandom_range(0, 15) != 0, is_last,
                       $urandom_range(0, 49) == 0);
          sent++;
        end
        if (split_end) begin
          send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0);
          sent++;
        end
      end
      if ($urandom_range(0, 59) == 0) wait_for_results_drained();
    end
  endtask

  task automatic test_reset_defaults();
    send_request(8'h00, 1'b0, 1'b1, 1'b0);
    send_request(8'h00, 1'b1, 1'b1, 1'b0);
    send_request(8'hff, 1'b1, 1'b1, 1'b0);
    send_request(8'ha5, 1'b1, 1'b0, 1'b0);
    send_request(8'h3c, 1'b0, 1'b0, 1'b0);
    send_request(8'h5a, 1'b1, 1'b1, 1'b0);
  endtask

  task automatic test_null_messages();
    send_request(8'h12, 1'b1, 1'b0, 1'b0);
    send_request(8'h34, 1'b1, 1'b0, 1'b1);
    send_request(8'hff, 1'b0, 1'b1, 1'b1);
    send_request(8'h7e, 1'b1, 1'b1, 1'b0);
  endtask

  task automatic test_fold_and_mix_extremes();
    write_register(CfgMixMode, 2'b10);
    write_register(CfgFoldWidth, FoldTo16);
    send_request(8'hff, 1'b1, 1'b0, 1'b0);
    send_request(8'h80, 1'b1, 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b1, 1'b0);
    write_register(CfgFoldWidth, FoldTo32);
    send_request(8'h01, 1'b1, 1'b1, 1'b0);
    write_register(CfgFoldWidth, FoldUnused);
    send_request(8'hff, 1'b1, 1'b1, 1'b0);
    write_register(CfgMixMode, 2'b11);
    write_register(CfgFoldWidth, FoldTo16);
    send_request(8'hff, 1'b1, 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b1, 1'b0);
  endtask

  task automatic test_random_traffic();
    logic [1:0] phase_mix[6] = '{2'd1, 2'd0, 2'd3, 2'd2, 2'd1, 2'd0};
    logic [1:0] phase_fold[6] = '{FoldTo64, FoldTo16, FoldTo16, FoldTo32, FoldUnused, FoldTo64};
    for (int p = 0; p < 6; p++) begin
      write_register(CfgMixMode, phase_mix[p]);
      write_register(CfgFoldWidth, phase_fold[p]);
      tx_gaps_on = (p % 3) != 0;
      rx_stall_on = (p % 2) != 0;
      send_message_stream(PhaseItems);
    end
  endtask

  always @(posedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_stall_on && $urandom_range(0, 3) == 0) begin
      rx_hold <= $urandom_range(0, 5);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_hashes.size() == 0) begin
        report_mismatch($sformatf("unexpected hash %h", m_axis_tdata));
      end else begin
        oldest_hash = pending_hashes.pop_front();
        if (m_axis_tdata !== oldest_hash) begin
          report_mismatch($sformatf("hash_value %h, expected %h", m_axis_tdata, oldest_hash));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_null_messages();
    test_fold_and_mix_extremes();
    test_random_traffic();
    wait_for_results_drained();
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
